// ----- rtl/core/link_emulator_rate_delay_loss_macros.svh -----
// Assertion macros for the link emulator.
// Define NO_ASSERTIONS to compile the checks away; used by the top level only.
`ifndef LINK_EMULATOR_RATE_DELAY_LOSS_MACROS_SVH
`define LINK_EMULATOR_RATE_DELAY_LOSS_MACROS_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define LEM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link emulator check failed");
// consequent checked in the cycle after the antecedent
`define LEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link emulator check failed");
`else
`define LEM_ASSERT_SAME(lbl, ante, cons)
`define LEM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/lnkemu_pkg.sv -----
// Shared types and constants of the link emulator.
// No dependencies; used by lnkemu_ctrl, lnkemu_dp and the top level.
`timescale 1ns / 1ps

package lnkemu_pkg;

    localparam int REQ_TIME_W = 48;
    localparam int LEN_W      = 16;
    localparam int TAG_W      = 16;
    localparam int DRAW_W     = 10;
    localparam int TRAIN_W    = 2;
    localparam int CODE_W     = 3;
    localparam int BURST_W    = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int BIT_TIME_W = 20;
    localparam int DELAY_W    = 24;
    localparam int LPM_W      = 10;

    // serialization time: length * 8 * bit_time
    localparam int MUL_W  = LEN_W + BIT_TIME_W;
    localparam int BUSY_W = MUL_W + 3;

    // results per request
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = 7;

    // shortest burst is two drops
    localparam int BURST_MIN = 2;

    localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST = BIT_TIME_W'(5);
    localparam logic [DELAY_W-1:0]    DELAY_RST    = DELAY_W'(150000);
    localparam logic                  LOSS_EN_RST  = 1'b0;
    localparam logic [LPM_W-1:0]      LPM_RST      = LPM_W'(10);
    localparam logic [LEN_W-1:0]      MAX_LEN_RST  = LEN_W'(1500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TIME = 3'd0,
        CFG_DELAY    = 3'd1,
        CFG_LOSS_EN  = 3'd2,
        CFG_LOSS_PM  = 3'd3,
        CFG_MAX_LEN  = 3'd4
    } cfg_index_t;

    typedef enum logic [CODE_W-1:0] {
        RES_ACCEPTED   = 3'd0,
        RES_LOST       = 3'd1,
        RES_FULL       = 3'd2,
        RES_BAD_LENGTH = 3'd3,
        RES_EMPTY      = 3'd4,
        RES_RELEASED   = 3'd5
    } res_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LINK,
        ST_ENQUEUE,
        ST_READ,
        ST_CHECK
    } lem_state_t;

    typedef struct packed {
        logic                  kind;
        logic [REQ_TIME_W-1:0] time_us;
        logic [LEN_W-1:0]      length;
        logic [TAG_W-1:0]      packet_tag;
        logic [DRAW_W-1:0]     loss_draw;
        logic [TRAIN_W-1:0]    train_draw;
    } request_t;

    typedef struct packed {
        logic [CODE_W-1:0] result_kind;
        logic [TAG_W-1:0]  packet_tag_res;
        logic [LEN_W-1:0]  length_res;
        logic              last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch request, clear result count
        logic set_code;     // hold the offer's own result
        logic link_update;  // advance link free time, burst state
        logic enqueue;      // write queue entry at tail
        logic head_read;    // read queue entry at head
        logic head_pop;     // pop head, emit held result (not last)
        logic finish;       // emit held result as last
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic      is_tick;
        res_code_t code;
        logic      held_accept;
        logic      release_ok;
    } dp_stat_t;

endpackage

// ----- rtl/core/lnkemu_ctrl.sv -----
// Controller of the link emulator: sequences classify, link, enqueue and release.
// Depends on lnkemu_pkg.
`timescale 1ns / 1ps

module lnkemu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lnkemu_pkg::dp_stat_t stat,
    output lnkemu_pkg::dp_cmd_t  cmd,
    output logic                busy
);

    lnkemu_pkg::lem_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lnkemu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lnkemu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lnkemu_pkg::ST_CLASSIFY;
                end
            end
            lnkemu_pkg::ST_CLASSIFY:
            begin
                if (stat.is_tick)
                begin
                    state_next = lnkemu_pkg::ST_READ;
                end
                else if (stat.code == lnkemu_pkg::RES_ACCEPTED ||
                         stat.code == lnkemu_pkg::RES_LOST)
                begin
                    state_next = lnkemu_pkg::ST_LINK;
                end
                else
                begin
                    state_next = lnkemu_pkg::ST_READ;
                end
            end
            lnkemu_pkg::ST_LINK:
            begin
                state_next = stat.held_accept ? lnkemu_pkg::ST_ENQUEUE
                                              : lnkemu_pkg::ST_READ;
            end
            lnkemu_pkg::ST_ENQUEUE:
            begin
                state_next = lnkemu_pkg::ST_READ;
            end
            lnkemu_pkg::ST_READ:
            begin
                state_next = lnkemu_pkg::ST_CHECK;
            end
            lnkemu_pkg::ST_CHECK:
            begin
                state_next = stat.release_ok ? lnkemu_pkg::ST_READ
                                             : lnkemu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lnkemu_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            lnkemu_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            lnkemu_pkg::ST_CLASSIFY:
            begin
                cmd.set_code = !stat.is_tick;
            end
            lnkemu_pkg::ST_LINK:
            begin
                cmd.link_update = 1'b1;
            end
            lnkemu_pkg::ST_ENQUEUE:
            begin
                cmd.enqueue = 1'b1;
            end
            lnkemu_pkg::ST_READ:
            begin
                cmd.head_read = 1'b1;
            end
            lnkemu_pkg::ST_CHECK:
            begin
                cmd.head_pop = stat.release_ok;
                cmd.finish   = !stat.release_ok;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/core/lnkemu_dp.sv -----
// Datapath of the link emulator: config registers, link timing, burst state,
// delay queue memory and the result register. Depends on lnkemu_pkg.
`timescale 1ns / 1ps

module lnkemu_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lnkemu_pkg::request_t                  request,
    input  logic                                  cfg_we,
    input  logic [lnkemu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lnkemu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  lnkemu_pkg::dp_cmd_t                   cmd,
    output lnkemu_pkg::dp_stat_t                  stat,
    output lnkemu_pkg::result_t                   result,
    output logic                                  result_strobe
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W   = ((TIME_WIDTH > lnkemu_pkg::BUSY_W) ? TIME_WIDTH
                                                                : lnkemu_pkg::BUSY_W) + 1;
    localparam int ENTRY_W = lnkemu_pkg::TAG_W + lnkemu_pkg::LEN_W + TIME_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [lnkemu_pkg::TAG_W-1:0] tag;
        logic [lnkemu_pkg::LEN_W-1:0] len;
        logic [TIME_WIDTH-1:0]        due;
    } entry_t;

    // configuration
    logic [lnkemu_pkg::BIT_TIME_W-1:0] bit_time_reg;
    logic [lnkemu_pkg::DELAY_W-1:0]    delay_reg;
    logic                              loss_en_reg;
    logic [lnkemu_pkg::LPM_W-1:0]      lpm_reg;
    logic [lnkemu_pkg::LEN_W-1:0]      max_len_reg;

    // control state
    logic [IDX_W-1:0]                  head_reg, tail_reg;
    logic [TIME_WIDTH-1:0]             free_reg;
    logic                              burst_active_reg;
    logic [lnkemu_pkg::BURST_W-1:0]    burst_count_reg, burst_len_reg;
    logic [lnkemu_pkg::CNT_W-1:0]      count_reg;
    logic                              held_valid_reg;
    logic                              strobe_reg;

    // payload
    lnkemu_pkg::request_t              req_reg;
    lnkemu_pkg::result_t               held_reg;
    lnkemu_pkg::result_t               out_reg;
    lnkemu_pkg::result_t               out_next;
    logic [lnkemu_pkg::BUSY_W-1:0]     prod_reg;
    logic [TIME_WIDTH-1:0]             start_reg;
    entry_t                            rd_reg;
    logic [ENTRY_W-1:0]                mem [QUEUE_DEPTH];

    logic [TIME_WIDTH-1:0]             now;
    logic [IDX_W-1:0]                  tail_inc, head_inc;
    logic [lnkemu_pkg::MUL_W-1:0]      mul;
    logic [SUM_W-1:0]                  link_sum, due_sum;
    logic [TIME_WIDTH-1:0]             free_next, due_val;
    logic                              lose;
    lnkemu_pkg::res_code_t             code;
    logic [lnkemu_pkg::BURST_W-1:0]    blen_eff, bcnt_inc;
    entry_t                            wr_entry;

    assign now      = TIME_WIDTH'(req_reg.time_us);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    // offer classification, in check order
    assign lose = loss_en_reg && ((req_reg.loss_draw < lpm_reg) || burst_active_reg);

    always_comb
    begin
        priority if (req_reg.length == '0)
        begin
            code = lnkemu_pkg::RES_EMPTY;
        end
        else if (req_reg.length > max_len_reg)
        begin
            code = lnkemu_pkg::RES_BAD_LENGTH;
        end
        else if (tail_inc == head_reg)
        begin
            code = lnkemu_pkg::RES_FULL;
        end
        else if (lose)
        begin
            code = lnkemu_pkg::RES_LOST;
        end
        else
        begin
            code = lnkemu_pkg::RES_ACCEPTED;
        end
    end

    // serialization time and link start time
    assign mul = req_reg.length * bit_time_reg;

    always_ff @(posedge clk)
    begin
        prod_reg  <= {mul, 3'b000};
        start_reg <= (now > free_reg) ? now : free_reg;
    end

    // saturating adds
    assign link_sum  = SUM_W'(start_reg) + SUM_W'(prod_reg);
    assign free_next = (link_sum[SUM_W-1:TIME_WIDTH] != '0) ? '1
                                                            : link_sum[TIME_WIDTH-1:0];
    assign due_sum   = SUM_W'(free_reg) + SUM_W'(delay_reg);
    assign due_val   = (due_sum[SUM_W-1:TIME_WIDTH] != '0) ? '1
                                                           : due_sum[TIME_WIDTH-1:0];

    // burst bookkeeping
    assign blen_eff = burst_active_reg ? burst_len_reg
                                       : lnkemu_pkg::BURST_W'(req_reg.train_draw)
                                         + lnkemu_pkg::BURST_W'(lnkemu_pkg::BURST_MIN);
    assign bcnt_inc = burst_count_reg + 1'b1;

    // status
    assign stat.is_tick     = req_reg.kind;
    assign stat.code        = code;
    assign stat.held_accept = (held_reg.result_kind == lnkemu_pkg::RES_ACCEPTED);
    assign stat.release_ok  = (head_reg != tail_reg) && (now >= rd_reg.due) &&
                              (count_reg < lnkemu_pkg::CNT_W'(lnkemu_pkg::RESULT_LIMIT));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg <= lnkemu_pkg::BIT_TIME_RST;
            delay_reg    <= lnkemu_pkg::DELAY_RST;
            loss_en_reg  <= lnkemu_pkg::LOSS_EN_RST;
            lpm_reg      <= lnkemu_pkg::LPM_RST;
            max_len_reg  <= lnkemu_pkg::MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lnkemu_pkg::CFG_BIT_TIME:
                    bit_time_reg <= cfg_data[lnkemu_pkg::BIT_TIME_W-1:0];
                lnkemu_pkg::CFG_DELAY:
                    delay_reg <= cfg_data[lnkemu_pkg::DELAY_W-1:0];
                lnkemu_pkg::CFG_LOSS_EN:
                    loss_en_reg <= cfg_data[0];
                lnkemu_pkg::CFG_LOSS_PM:
                    lpm_reg <= cfg_data[lnkemu_pkg::LPM_W-1:0];
                lnkemu_pkg::CFG_MAX_LEN:
                    max_len_reg <= cfg_data[lnkemu_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
    end

    // link time, burst state, queue pointers, result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg         <= '0;
            burst_active_reg <= 1'b0;
            burst_count_reg  <= '0;
            burst_len_reg    <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            held_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                count_reg      <= '0;
                held_valid_reg <= 1'b0;
            end
            if (cmd.set_code)
            begin
                count_reg      <= lnkemu_pkg::CNT_W'(1);
                held_valid_reg <= 1'b1;
            end
            if (cmd.link_update)
            begin
                free_reg <= free_next;
                if (held_reg.result_kind == lnkemu_pkg::RES_LOST)
                begin
                    if (bcnt_inc >= blen_eff)
                    begin
                        burst_active_reg <= 1'b0;
                        burst_count_reg  <= '0;
                        burst_len_reg    <= '0;
                    end
                    else
                    begin
                        burst_active_reg <= 1'b1;
                        burst_count_reg  <= bcnt_inc;
                        burst_len_reg    <= blen_eff;
                    end
                end
            end
            if (cmd.enqueue)
            begin
                tail_reg <= tail_inc;
            end
            if (cmd.head_pop)
            begin
                head_reg       <= head_inc;
                count_reg      <= count_reg + 1'b1;
                held_valid_reg <= 1'b1;
            end
        end
    end

    // delay queue memory
    assign wr_entry = '{tag: req_reg.packet_tag, len: req_reg.length, due: due_val};

    always_ff @(posedge clk)
    begin
        if (cmd.enqueue)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (cmd.head_read)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    // held result: the offer's own code, then each released entry
    always_ff @(posedge clk)
    begin
        if (cmd.set_code)
        begin
            held_reg.result_kind    <= code;
            held_reg.packet_tag_res <= req_reg.packet_tag;
            held_reg.length_res     <= req_reg.length;
            held_reg.last           <= 1'b0;
        end
        else if (cmd.head_pop)
        begin
            held_reg.result_kind    <= lnkemu_pkg::RES_RELEASED;
            held_reg.packet_tag_res <= rd_reg.tag;
            held_reg.length_res     <= rd_reg.len;
            held_reg.last           <= 1'b0;
        end
    end

    // output register: a held result goes out once the next one is known
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.head_pop || cmd.finish) && held_valid_reg;
        end
    end

    // outgoing result: the held one, marked last on finish
    always_comb
    begin
        out_next      = held_reg;
        out_next.last = cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_pop || cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign result        = out_reg;
    assign result_strobe = strobe_reg;

endmodule

// ----- rtl/core/link_emulator_rate_delay_loss.sv -----
// Bottleneck link emulator: rate limit, propagation delay and burst loss.
//
// Request channel: start, busy, request. A request is taken at a clock edge
// with start high and busy low. kind 0 offers a packet, kind 1 is a tick
// that only releases packets whose due time has come.
// Result channel: result and result_strobe. Each result is shown for exactly
// one cycle with result_strobe high; the receiver cannot stall it. The last
// result caused by a request carries last = 1; a tick with nothing due gives
// none. An offer gives its own code first, then any releases.
// Configuration: cfg_we, cfg_index, cfg_data; the user must see that it is
// written only while idle, as the block itself does not enforce this. After
// a request is taken, the sequencer classifies it, adds the link time for
// an accepted or lost offer, writes the queue memory for an accepted one,
// then makes each release check as a registered queue read followed by a
// compare. busy stays high until the sequencer is back in idle, so no new
// request is taken before the last one is done.
// Reset clears the link time, the burst state and the queue pointers and
// loads the register defaults; the queue memory itself is not cleared.
`timescale 1ns / 1ps
`include "link_emulator_rate_delay_loss_macros.svh"

module link_emulator_rate_delay_loss #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lnkemu_pkg::request_t              request,
    input  logic                              cfg_we,
    input  logic [lnkemu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lnkemu_pkg::CFG_DATA_W-1:0] cfg_data,
    output lnkemu_pkg::result_t               result,
    output logic                              result_strobe
);

    lnkemu_pkg::dp_cmd_t  cmd;
    lnkemu_pkg::dp_stat_t stat;

    // sequencer
    lnkemu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath and queue
    lnkemu_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // checks
    `LEM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LEM_ASSERT_SAME(a_last_idle, result_strobe && result.last, !busy)
    `LEM_ASSERT_SAME(a_more_busy, result_strobe && !result.last, busy)
    `LEM_ASSERT_NEXT(a_idle_quiet, !busy, !result_strobe)

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for link_emulator_rate_delay_loss: a directed table, then random
// traffic under several register settings, checked against a cycle-free link predictor.
// Depends on lnkemu_pkg and the RTL of the link emulator.
`timescale 1ns / 1ps

module tb_top;

    import lnkemu_pkg::*;

    localparam int          FIFO_DEPTH   = 64;
    localparam int          FIFO_IDX_W   = $clog2(FIFO_DEPTH);
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          SETTLE_CYCLES = 16;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic        KIND_OFFER   = 1'b0;
    localparam logic        KIND_TICK    = 1'b1;
    // typed_n value for rows whose results come from the predictor
    localparam int          PREDICTED    = -1;
    localparam int          PHASE_ITEMS  = 70;
    localparam int          FILL_OFFERS  = 66;

    // register values after reset
    localparam logic [19:0] BIT_TIME_INIT = 20'd5;
    localparam logic [23:0] DELAY_INIT    = 24'd150000;
    localparam logic [9:0]  LOSS_PM_INIT  = 10'd10;
    localparam logic [15:0] MAX_LEN_INIT  = 16'd1500;

    typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t    op;
        request_t   rq;
        cfg_index_t idx;
        logic [23:0] val;
        int         typed_n;
        res_code_t  typed_code;
    } table_row_t;

    typedef struct {
        logic [19:0] bit_time;
        logic [23:0] delay;
        logic        loss_en;
        logic [9:0]  loss_pm;
        logic [15:0] max_len;
        int unsigned step;
        bit          gaps_on;
    } link_setting_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    result_t     result;
    logic        result_strobe;

    // link predictor state
    logic [19:0] lk_bit_time;
    logic [23:0] lk_delay;
    logic        lk_loss_en;
    logic [9:0]  lk_loss_pm;
    logic [15:0] lk_max_len;
    logic [15:0] fifo_tag [FIFO_DEPTH];
    logic [15:0] fifo_len [FIFO_DEPTH];
    logic [47:0] fifo_due [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] fifo_head;
    logic [FIFO_IDX_W-1:0] fifo_tail;
    logic [47:0] link_free;
    logic        burst_on;
    logic [2:0]  burst_cnt;
    logic [2:0]  burst_len;

    result_t     step_results [$];
    result_t     pending_results [$];
    table_row_t  table_rows [$];
    link_setting_t settings [6];
    logic [47:0] now_us;
    bit          gaps_on;
    int          err_count;
    int          cycle_count;

    link_emulator_rate_delay_loss i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        $display("tb_top: mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [47:0] time_sat_add(input logic [47:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return (s > 65'(TIME_MAX)) ? TIME_MAX : s[47:0];
    endfunction

    // serialization: link busy from max(now, free) for length * 8 * bit time
    function automatic void occupy_link_time(input logic [47:0] t_us, input logic [15:0] len);
        logic [47:0] from;
        from = (t_us > link_free) ? t_us : link_free;
        link_free = time_sat_add(from, 64'(len) * 64'd8 * 64'(lk_bit_time));
    endfunction

    // results of one request, in order, into step_results
    function automatic void predict_link_step(input request_t rq);
        result_t               r;
        res_code_t             code;
        logic [FIFO_IDX_W-1:0] nxt;
        step_results.delete();
        if (rq.kind == KIND_OFFER)
        begin
            nxt = fifo_tail + 1'b1;
            if (rq.length == 16'd0)
                code = RES_EMPTY;
            else if (rq.length > lk_max_len)
                code = RES_BAD_LENGTH;
            else if (nxt == fifo_head)
                code = RES_FULL;
            else if (lk_loss_en && (rq.loss_draw < lk_loss_pm || burst_on))
            begin
                if (!burst_on)
                    burst_len = 3'(rq.train_draw) + 3'(BURST_MIN);
                burst_on = 1'b1;
                occupy_link_time(rq.time_us, rq.length);
                burst_cnt = burst_cnt + 3'd1;
                if (burst_cnt >= burst_len)
                begin
                    burst_on  = 1'b0;
                    burst_cnt = 3'd0;
                    burst_len = 3'd0;
                end
                code = RES_LOST;
            end
            else
            begin
                occupy_link_time(rq.time_us, rq.length);
                fifo_tag[fifo_tail] = rq.packet_tag;
                fifo_len[fifo_tail] = rq.length;
                fifo_due[fifo_tail] = time_sat_add(link_free, 64'(lk_delay));
                fifo_tail = nxt;
                code = RES_ACCEPTED;
            end
            r.result_kind    = code;
            r.packet_tag_res = rq.packet_tag;
            r.length_res     = rq.length;
            r.last           = 1'b0;
            step_results.push_back(r);
        end
        // release due head entries, up to the per-request result cap
        while (step_results.size() < RESULT_LIMIT && fifo_head != fifo_tail &&
               rq.time_us >= fifo_due[fifo_head])
        begin
            r.result_kind    = RES_RELEASED;
            r.packet_tag_res = fifo_tag[fifo_head];
            r.length_res     = fifo_len[fifo_head];
            r.last           = 1'b0;
            step_results.push_back(r);
            fifo_head = fifo_head + 1'b1;
        end
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    // present one request, hold it until taken, then queue what it should produce
    task automatic send_request(input request_t rq, input int typed_n, input res_code_t typed_code);
        result_t r;
        @(negedge clk);
        request = rq;
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_link_step(rq);
        if (typed_n == PREDICTED)
        begin
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        end
        else if (typed_n == 1)
        begin
            r.result_kind    = typed_code;
            r.packet_tag_res = rq.packet_tag;
            r.length_res     = rq.length;
            r.last           = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // sender idle time: mostly none or short, now and then long
    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        if (!gaps_on)
            return;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // hold off until every expected result is in and the block is quiet
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            CFG_BIT_TIME: lk_bit_time = val[19:0];
            CFG_DELAY:    lk_delay    = val;
            CFG_LOSS_EN:  lk_loss_en  = val[0];
            CFG_LOSS_PM:  lk_loss_pm  = val[9:0];
            CFG_MAX_LEN:  lk_max_len  = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic table_row_t req_row(input logic kind, input logic [47:0] t_us,
                                           input logic [15:0] len, input logic [15:0] tag,
                                           input logic [9:0] ldraw, input logic [1:0] tdraw,
                                           input int typed_n, input res_code_t typed_code);
        table_row_t row;
        row.op            = ROW_REQ;
        row.rq.kind       = kind;
        row.rq.time_us    = t_us;
        row.rq.length     = len;
        row.rq.packet_tag = tag;
        row.rq.loss_draw  = ldraw;
        row.rq.train_draw = tdraw;
        row.idx           = CFG_BIT_TIME;
        row.val           = '0;
        row.typed_n       = typed_n;
        row.typed_code    = typed_code;
        return row;
    endfunction

    function automatic table_row_t cfg_row(input cfg_index_t idx, input logic [23:0] val);
        table_row_t row;
        row = req_row(KIND_TICK, '0, '0, '0, '0, '0, 0, RES_EMPTY);
        row.op  = ROW_CFG;
        row.idx = idx;
        row.val = val;
        return row;
    endfunction

    task automatic run_table();
        table_row_t row;
        while (table_rows.size() != 0)
        begin
            row = table_rows.pop_front();
            if (row.op == ROW_CFG)
            begin
                wait_idle();
                cfg_write(row.idx, row.val);
            end
            else
            begin
                send_request(row.rq, row.typed_n, row.typed_code);
                sender_gap();
            end
        end
    endtask

    // random request under the current settings; moves now_us forward
    function automatic request_t random_request(input int unsigned step);
        request_t    rq;
        int unsigned r;
        int unsigned w;
        int unsigned cap;
        logic [47:0] back;
        r = $urandom_range(0, 99);
        w = $urandom_range(0, 99);
        rq.kind       = (r < 10) ? KIND_TICK : KIND_OFFER;
        rq.packet_tag = 16'($urandom_range(0, 65535));
        rq.loss_draw  = (w < 6) ? 10'($urandom_range(1000, 1023)) : 10'($urandom_range(0, 999));
        rq.train_draw = 2'($urandom_range(0, 3));
        // ticks jump ahead by the step plus up to one delay; a few offers look back in time
        w = $urandom_range(0, 99);
        if (rq.kind == KIND_TICK)
            now_us = now_us + 48'(step) + 48'($urandom_range(0, lk_delay));
        else if (w >= 8)
            now_us = now_us + 48'($urandom_range(0, step));
        back = (w < 4) ? 48'($urandom_range(0, step)) : 48'd0;
        rq.time_us = (now_us >= back) ? now_us - back : now_us;
        cap = (lk_max_len < 16'd1500) ? lk_max_len : 1500;
        if (rq.kind == KIND_TICK)
            rq.length = 16'($urandom_range(0, 65535));
        else if (r < 15 || lk_max_len == 16'd0)
            rq.length = 16'd0;
        else if (r < 22 && lk_max_len != 16'hFFFF)
            rq.length = 16'($urandom_range(lk_max_len + 1, 65535));
        else if (r < 25)
            rq.length = lk_max_len;
        else if (r < 40)
            rq.length = 16'($urandom_range(1, lk_max_len));
        else
            rq.length = 16'($urandom_range(1, cap));
        return rq;
    endfunction

    task automatic apply_setting(input link_setting_t s);
        wait_idle();
        cfg_write(CFG_BIT_TIME, 24'(s.bit_time));
        cfg_write(CFG_DELAY, s.delay);
        cfg_write(CFG_LOSS_EN, 24'(s.loss_en));
        cfg_write(CFG_LOSS_PM, 24'(s.loss_pm));
        cfg_write(CFG_MAX_LEN, 24'(s.max_len));
        gaps_on = s.gaps_on;
    endtask

    // fill the queue at one instant, overflow it, then release all with a full offer
    task automatic fill_and_drain();
        request_t rq;
        wait_idle();
        cfg_write(CFG_BIT_TIME, 24'd0);
        cfg_write(CFG_DELAY, 24'hFF_FFFF);
        cfg_write(CFG_LOSS_EN, 24'd0);
        cfg_write(CFG_MAX_LEN, 24'hFFFF);
        gaps_on = 1'b1;
        now_us = now_us + (48'd1 << 37);
        rq = random_request(0);
        rq.kind    = KIND_TICK;
        rq.time_us = now_us;
        send_request(rq, PREDICTED, RES_ACCEPTED);
        repeat (FILL_OFFERS + 1)
        begin
            rq = random_request(0);
            rq.kind    = KIND_OFFER;
            rq.time_us = now_us;
            rq.length  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                     : 16'($urandom_range(1, 1500));
            if (rq.loss_draw >= 10'd1000)
                rq.loss_draw = 10'd0;
            send_request(rq, PREDICTED, RES_ACCEPTED);
            sender_gap();
        end
        now_us = now_us + 48'hFF_FFFF;
        rq.time_us    = now_us;
        rq.packet_tag = 16'($urandom_range(0, 65535));
        send_request(rq, PREDICTED, RES_ACCEPTED);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_strobe)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf("result with nothing expected, kind %0d tag %h",
                                       result.result_kind, result.packet_tag_res));
            else
            begin
                e = pending_results.pop_front();
                if (result.result_kind != e.result_kind)
                    log_mismatch($sformatf("result_kind %0d, expected %0d",
                                           result.result_kind, e.result_kind));
                if (result.packet_tag_res != e.packet_tag_res)
                    log_mismatch($sformatf("packet_tag_res %h, expected %h",
                                           result.packet_tag_res, e.packet_tag_res));
                if (result.length_res != e.length_res)
                    log_mismatch($sformatf("length_res %0d, expected %0d",
                                           result.length_res, e.length_res));
                if (result.last != e.last)
                    log_mismatch($sformatf("last %b, expected %b", result.last, e.last));
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        err_count = 0;
        now_us    = '0;
        gaps_on   = 1'b1;
        lk_bit_time = BIT_TIME_INIT;
        lk_delay    = DELAY_INIT;
        lk_loss_en  = 1'b0;
        lk_loss_pm  = LOSS_PM_INIT;
        lk_max_len  = MAX_LEN_INIT;
        fifo_head   = '0;
        fifo_tail   = '0;
        link_free   = '0;
        burst_on    = 1'b0;
        burst_cnt   = 3'd0;
        burst_len   = 3'd0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, length checks, a burst across loss toggles
        table_rows.push_back(req_row(KIND_TICK, 48'd0, 16'd0, 16'd0, 10'd0, 2'd0, 0, RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd0, 16'd0, 16'hFFFF, 10'd0, 2'd0, 1,
                                     RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd0, 16'd1501, 16'h1234, 10'd0, 2'd0, 1,
                                     RES_BAD_LENGTH));
        table_rows.push_back(req_row(KIND_OFFER, 48'd0, 16'hFFFF, 16'hFFFF, 10'h3FF, 2'd3, 1,
                                     RES_BAD_LENGTH));
        table_rows.push_back(req_row(KIND_OFFER, 48'd0, 16'd1, 16'h0000, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd10, 16'd1500, 16'hFFFF, 10'd999, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, 48'd150039, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, 48'd150040, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, 48'd300000, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(cfg_row(CFG_LOSS_EN, 24'd1));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd100, 16'h0011, 10'd9, 2'd0, 1,
                                     RES_LOST));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd100, 16'h0012, 10'd999, 2'd1,
                                     1, RES_LOST));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd100, 16'h0013, 10'd10, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd200, 16'h0014, 10'd5, 2'd3, 1,
                                     RES_LOST));
        table_rows.push_back(cfg_row(CFG_LOSS_EN, 24'd0));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd200, 16'h0015, 10'd5, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(cfg_row(CFG_LOSS_EN, 24'd1));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd300, 16'h0016, 10'd999, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(cfg_row(CFG_MAX_LEN, 24'd0));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd0, 16'h0017, 10'd0, 2'd0, 1,
                                     RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'd1, 16'h0018, 10'd0, 2'd0, 1,
                                     RES_BAD_LENGTH));
        table_rows.push_back(cfg_row(CFG_LOSS_PM, 24'd1023));
        table_rows.push_back(cfg_row(CFG_MAX_LEN, 24'hFFFF));
        table_rows.push_back(req_row(KIND_OFFER, 48'd400000, 16'hFFFF, 16'h0019, 10'h3FF, 2'd2,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, 48'd4000000, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        run_table();
        now_us = 48'd4000000;

        // random traffic under a spread of link settings
        settings[0] = '{20'd5, 24'd150000, 1'b0, 10'd10, 16'd1500, 40000, 1'b1};
        settings[1] = '{20'd0, 24'd0, 1'b1, 10'd200, 16'hFFFF, 50, 1'b0};
        settings[2] = '{20'd1, 24'd1000, 1'b1, 10'd1000, 16'hFFFF, 5000, 1'b1};
        settings[3] = '{20'd1000000, 24'hFF_FFFF, 1'b1, 10'd0, 16'd64, 300000000, 1'b1};
        settings[4] = '{20'd2, 24'd500, 1'b0, 10'd1023, 16'd1, 20, 1'b1};
        settings[5] = '{20'd3, 24'd20000, 1'b1, 10'd50, 16'd9000, 20000, 1'b1};
        foreach (settings[p])
        begin
            apply_setting(settings[p]);
            repeat (PHASE_ITEMS)
            begin
                send_request(random_request(settings[p].step), PREDICTED, RES_ACCEPTED);
                // now and then hold the sender until the block has drained
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
                else
                    sender_gap();
            end
        end
        fill_and_drain();

        // time saturation at the top of the time range, with a look back
        table_rows.push_back(cfg_row(CFG_BIT_TIME, 24'd1000000));
        table_rows.push_back(cfg_row(CFG_DELAY, 24'hFF_FFFF));
        table_rows.push_back(cfg_row(CFG_LOSS_EN, 24'd0));
        table_rows.push_back(cfg_row(CFG_MAX_LEN, 24'hFFFF));
        table_rows.push_back(req_row(KIND_TICK, 48'hFFFF_FFFE_0000, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'hFFFF_FFFF_0000, 16'hFFFF, 16'hA5A5, 10'd0,
                                     2'd0, PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_OFFER, 48'd5, 16'd1, 16'h5A5A, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, 48'hFFFF_FFFF_FFFE, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        table_rows.push_back(req_row(KIND_TICK, TIME_MAX, 16'd0, 16'd0, 10'd0, 2'd0,
                                     PREDICTED, RES_EMPTY));
        run_table();

        wait_idle();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- link_emulator_rate_delay_loss.f -----
+incdir+rtl/core
rtl/core/lnkemu_pkg.sv
rtl/core/lnkemu_ctrl.sv
rtl/core/lnkemu_dp.sv
rtl/core/link_emulator_rate_delay_loss.sv
sim/tb_top.sv
